### src/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// Used by the entry table and by the top level; depends on nothing.
package ffba_pkg;

  // Width of every address and size in the heap.
  localparam int unsigned ADDR_BITS = 24;

  // Wide enough for an address plus a header plus a size without wrapping.
  localparam int unsigned SUM_BITS = ADDR_BITS + 2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  // Answer codes of one request.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NULL      = 3'd1,
    STAT_EXHAUSTED = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_UNKNOWN   = 3'd4
  } status_e;

  // Request kinds carried in tuser.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // One row of the block table.
  typedef struct packed {
    addr_t start;
    addr_t size;
    logic  free;
  } entry_t;

  // Write request into the table (the index travels beside it).
  typedef struct packed {
    logic   we;
    entry_t data;
  } tbl_wr_t;

endpackage

### src/ffba_table.sv
// Block table memory of the first-fit block allocator: one write port and
// one read port with registered read data. Depends on ffba_pkg.
module ffba_table import ffba_pkg::*; #(
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  tbl_wr_t                  wr_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/first_fit_block_allocator.sv
// First-fit block allocator: sequencer, heap registers and the block table.
// A null request, or a free of an empty table, goes straight to its answer;
// other requests scan the entries in order, and an allocate that finds no fit,
// or meets an empty table, grows the heap. One item at a time, taken as the
// answer appears. Reset empties the table at once, with no sweep.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] request_size, [47:24] payload_address
  input  logic        s_axis_tuser,   // [0] operation
  // Answer stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] result_address
  output logic [3:0]  m_axis_tuser,   // [0] reused, [3:1] status
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Table index and entry count widths follow from the table depth.
  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam sum_t HdrSum = SUM_BITS'(HEADER_BYTES);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_GROW = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers. Bit 2 of the byte address picks the register;
  // the low bits are byte offsets inside the word.
  // ---------------------------------------------------------------------
  addr_t base_q, limit_q;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= ADDR_BITS'(4096);
      limit_q <= ADDR_BITS'(16777215);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        limit_q <= pwdata[ADDR_BITS-1:0];
      end else begin
        base_q <= pwdata[ADDR_BITS-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(limit_q) : 32'(base_q);

  // ---------------------------------------------------------------------
  // Sequencer state and the latched request.
  // ---------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            op_q;
  addr_t           req_size_q, req_addr_q;
  addr_t           brk_q, brk_d;

  // The answer being built and the output register that holds it.
  addr_t   res_addr_q, res_addr_d;
  logic    res_reused_q, res_reused_d;
  status_e res_status_q, res_status_d;
  logic    out_vld_q;
  addr_t   out_addr_q;
  logic    out_reused_q;
  status_e out_status_q;

  // Table ports.
  tbl_wr_t         tbl_wr;
  logic [IdxW-1:0] tbl_waddr, tbl_raddr;
  entry_t          ent;

  ffba_table #(
    .Depth(MAX_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .wr_i   (tbl_wr),
    .waddr_i(tbl_waddr),
    .raddr_i(tbl_raddr),
    .rdata_o(ent)
  );

  logic  in_acc;
  logic  out_free;
  logic  last_ent;
  sum_t  ent_pay;
  sum_t  grow_end;
  logic  grow_ok;
  logic  is_free_op;
  addr_t in_size, in_addr;

  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign out_free   = !out_vld_q || m_axis_tready;
  assign is_free_op = (op_q == OP_FREE);
  assign in_size    = s_axis_tdata[23:0];
  assign in_addr    = s_axis_tdata[47:24];

  // The compare unit that the scan uses once per entry. The entry under
  // test is the one read in the previous cycle; the next one is read now.
  assign last_ent  = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign ent_pay   = SUM_BITS'(ent.start) + HdrSum;
  assign tbl_raddr = (state_q == S_SCAN) ? idx_q + IdxW'(1) : '0;

  // Growth check: the new end must stay inside both the limit and the
  // address space, and the table must not be full.
  assign grow_end = SUM_BITS'(brk_q) + HdrSum + SUM_BITS'(req_size_q);
  assign grow_ok  = (grow_end <= SUM_BITS'(limit_q)) && (count_q != CntMax);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    brk_d        = brk_q;
    res_addr_d   = res_addr_q;
    res_reused_d = res_reused_q;
    res_status_d = res_status_q;
    tbl_wr       = '0;
    tbl_waddr    = idx_q;

    case (state_q)
      S_IDLE: begin
        idx_d        = '0;
        res_addr_d   = '0;
        res_reused_d = 1'b0;
        if (in_acc) begin
          if ((s_axis_tuser == OP_ALLOC && in_size == '0) ||
              (s_axis_tuser == OP_FREE && in_addr == '0)) begin
            res_status_d = STAT_NULL;
            state_d      = S_DONE;
          end else if (count_q != '0) begin
            state_d = S_SCAN;
          end else if (s_axis_tuser == OP_ALLOC) begin
            // Empty table: the break sits at the heap base.
            brk_d   = base_q;
            state_d = S_GROW;
          end else begin
            res_status_d = STAT_UNKNOWN;
            state_d      = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (is_free_op) begin
          if (ent_pay == SUM_BITS'(req_addr_q)) begin
            // Freeing the last entry drops it; any other is only marked.
            if (last_ent) begin
              count_d = count_q - CntW'(1);
            end else begin
              tbl_wr.we   = 1'b1;
              tbl_wr.data = '{start: ent.start, size: ent.size, free: 1'b1};
            end
            res_status_d = STAT_OK;
            state_d      = S_DONE;
          end else if (last_ent) begin
            res_status_d = STAT_UNKNOWN;
            state_d      = S_DONE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else begin
          if (ent.free && ent.size >= req_size_q) begin
            tbl_wr.we    = 1'b1;
            tbl_wr.data  = '{start: ent.start, size: ent.size, free: 1'b0};
            res_addr_d   = ent_pay[ADDR_BITS-1:0];
            res_reused_d = 1'b1;
            res_status_d = STAT_OK;
            state_d      = S_DONE;
          end else if (last_ent) begin
            // No fit: the last entry just read gives the break.
            brk_d   = ADDR_BITS'(ent_pay + SUM_BITS'(ent.size));
            state_d = S_GROW;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      S_GROW: begin
        tbl_waddr = count_q[IdxW-1:0];
        state_d   = S_DONE;
        if (grow_end > SUM_BITS'(limit_q)) begin
          res_status_d = STAT_EXHAUSTED;
        end else if (count_q == CntMax) begin
          res_status_d = STAT_FULL;
        end else begin
          tbl_wr.we    = 1'b1;
          tbl_wr.data  = '{start: brk_q, size: req_size_q, free: 1'b0};
          count_d      = count_q + CntW'(1);
          res_addr_d   = ADDR_BITS'(SUM_BITS'(brk_q) + HdrSum);
          res_status_d = STAT_OK;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    brk_q        <= brk_d;
    res_addr_q   <= res_addr_d;
    res_reused_q <= res_reused_d;
    res_status_q <= res_status_d;
    if (in_acc) begin
      op_q       <= s_axis_tuser;
      req_size_q <= in_size;
      req_addr_q <= in_addr;
    end
    if (state_q == S_DONE && out_free) begin
      out_addr_q   <= res_addr_q;
      out_reused_q <= res_reused_q;
      out_status_q <= res_status_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = {out_status_q, out_reused_q};

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count above table depth");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CntW'(idx_q) < count_q)
    else $error("scan index outside valid entries");

  a_grow_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GROW && grow_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("append did not bump the entry count");

  a_reuse_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == STAT_OK)
    else $error("reused answer with an error status");

endmodule

### verif/tb_first_fit_block_allocator.sv
// Self-checking testbench for the first-fit block allocator.
// Depends on ffba_pkg and first_fit_block_allocator; it has its own table
// model and a random handshake on both streams.
module tb_first_fit_block_allocator import ffba_pkg::*; ();

  // The block is built with its default table depth and header size, and the
  // model below mirrors both.
  localparam int unsigned MAX_BLOCKS     = 64;
  localparam int unsigned HEADER_BYTES   = 24;
  // The slowest request is a full table scan followed by growth. The quiet-time
  // limit is well beyond any correct run, including the hold-off.
  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = MAX_BLOCKS + 8;

  // Byte addresses of the two registers on the APB port.
  localparam logic [2:0] REG_HEAP_BASE  = 3'd0;
  localparam logic [2:0] REG_HEAP_LIMIT = 3'd4;

  localparam addr_t ADDR_MAX        = '1;
  localparam addr_t RESET_BASE      = 24'd4096;
  localparam addr_t RESET_LIMIT     = 24'hFFFFFF;

  // One answer as the block should return it.
  typedef struct packed {
    addr_t   address;
    logic    reused;
    status_e status;
  } answer_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // [23:0] request_size, [47:24] payload_address
  logic        s_axis_tuser  = 1'b0; // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [23:0] result_address
  logic [3:0]  m_axis_tuser;         // [0] reused, [3:1] status
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Model of the block table: address-ordered entries, the count of valid
  // ones, and the two heap registers.
  addr_t       blk_start [MAX_BLOCKS];
  addr_t       blk_size  [MAX_BLOCKS];
  logic        blk_free  [MAX_BLOCKS];
  int unsigned blk_count      = 0;
  addr_t       cfg_heap_base  = RESET_BASE;
  addr_t       cfg_heap_limit = RESET_LIMIT;

  // Answers still owed by the block, oldest first.
  answer_t     expected_answers[$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  // Percentage of cycles in which the receiver holds back, and of requests before which the sender pauses.
  int unsigned idle_pct    = 33;
  // Set while the receiver refuses every answer for a long stretch.
  logic        holding     = 1'b0;
  event        start_holdoff;

  first_fit_block_allocator #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to the table model and returns the answer it calls
  // for. For an allocate the value is the size, for a free the address.
  function automatic answer_t predict_answer(op_e op, addr_t value);
    answer_t         ans;
    longint unsigned brk;
    longint unsigned top;
    int unsigned     last;
    ans = '{address: '0, reused: 1'b0, status: STAT_OK};
    if (op == OP_ALLOC) begin
      if (value == '0) begin
        ans.status = STAT_NULL;
        return ans;
      end
      // First fit: the lowest free entry that is large enough keeps its size.
      for (int k = 0; k < blk_count; k++) begin
        if (blk_free[k] && blk_size[k] >= value) begin
          blk_free[k] = 1'b0;
          ans.address = blk_start[k] + addr_t'(HEADER_BYTES);
          ans.reused  = 1'b1;
          return ans;
        end
      end
      // No fit, so the heap grows at the break. The limit check comes
      // before the table-full check.
      if (blk_count == 0) begin
        brk = cfg_heap_base;
      end else begin
        last = blk_count - 1;
        brk  = 64'(blk_start[last]) + HEADER_BYTES + blk_size[last];
      end
      top = brk + HEADER_BYTES + value;
      if (top > cfg_heap_limit || top > ADDR_MAX) begin
        ans.status = STAT_EXHAUSTED;
      end else if (blk_count >= MAX_BLOCKS) begin
        ans.status = STAT_FULL;
      end else begin
        blk_start[blk_count] = addr_t'(brk);
        blk_size[blk_count]  = value;
        blk_free[blk_count]  = 1'b0;
        blk_count++;
        ans.address = addr_t'(brk + HEADER_BYTES);
      end
    end else begin
      if (value == '0) begin
        ans.status = STAT_NULL;
        return ans;
      end
      ans.status = STAT_UNKNOWN;
      for (int k = 0; k < blk_count; k++) begin
        if (64'(blk_start[k]) + HEADER_BYTES == value) begin
          // The last entry goes away and lowers the break; any other entry is
          // only marked, and neighbors are never merged.
          if (k + 1 == blk_count) begin
            blk_count--;
          end else begin
            blk_free[k] = 1'b1;
          end
          ans.status = STAT_OK;
          return ans;
        end
      end
    end
    return ans;
  endfunction

  function automatic addr_t payload_of(int unsigned k);
    return blk_start[k] + addr_t'(HEADER_BYTES);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offers one request and returns once the block has taken it. The field the
  // operation does not use carries random bits. Starts and ends at a falling
  // edge; the valid stays high so that back-to-back items need no gap.
  task automatic send_request(input op_e op, input addr_t value, output answer_t ans);
    addr_t filler;
    filler = addr_t'($urandom);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= (op == OP_ALLOC) ? {filler, value} : {value, filler};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    ans = predict_answer(op, value);
    expected_answers.push_back(ans);
    @(negedge clk_i);
  endtask

  // Stops offering, lets every owed answer come back and then gives the block
  // a full scan time to settle, so that registers change only while it idles.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One APB transfer: the setup phase, then the access phase until pready.
  task automatic apb_transfer(input logic is_write, input logic [2:0] where,
                              input addr_t value, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= where;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_register(input logic [2:0] where, input addr_t want);
    logic [31:0] rdata;
    apb_transfer(1'b0, where, '0, rdata);
    if (rdata !== 32'(want)) report_mismatch("register readback", rdata, 32'(want));
  endtask

  task automatic write_register(input logic [2:0] where, input addr_t value);
    logic [31:0] rdata;
    wait_idle();
    apb_transfer(1'b1, where, value, rdata);
    if (where == REG_HEAP_BASE) begin
      cfg_heap_base = value;
    end else begin
      cfg_heap_limit = value;
    end
    check_register(where, value);
  endtask

  // Frees the last entry until the table is empty, so that heap_base counts
  // again for the next allocate.
  task automatic drain_table();
    answer_t ans;
    while (blk_count > 0) send_request(OP_FREE, payload_of(blk_count - 1), ans);
  endtask

  // One random request. Most are well-formed allocates and frees of live
  // entries; the rest are null requests, near-miss and random addresses, and
  // oversized allocates.
  task automatic send_random_item(input int unsigned alloc_pct, input int unsigned size_cap);
    answer_t     ans;
    int unsigned pick;
    int unsigned k;
    addr_t       delta;
    pick = $urandom_range(99);
    k    = (blk_count > 0) ? $urandom_range(blk_count - 1) : 0;
    if (pick < 6) begin
      send_request(OP_ALLOC, '0, ans);
    end else if (pick < 10) begin
      send_request(OP_FREE, '0, ans);
    end else if (pick < 14 && blk_count > 0) begin
      // Just beside a payload address: never the payload address of any entry.
      delta = addr_t'($urandom_range(1, HEADER_BYTES));
      send_request(OP_FREE, $urandom_range(1) ? payload_of(k) + delta
                                              : payload_of(k) - delta, ans);
    end else if (pick < 16) begin
      send_request(OP_FREE, addr_t'($urandom), ans);
    end else if (pick < 18) begin
      send_request(OP_ALLOC, addr_t'($urandom), ans);
    end else if (blk_count > 0 && $urandom_range(99) >= alloc_pct) begin
      // Freeing the last entry often keeps the break moving both ways.
      if ($urandom_range(99) < 30) k = blk_count - 1;
      send_request(OP_FREE, payload_of(k), ans);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70 || blk_count == 0) begin
        send_request(OP_ALLOC, addr_t'($urandom_range(1, size_cap)), ans);
      end else if (pick < 85) begin
        send_request(OP_ALLOC, blk_size[k], ans);
      end else begin
        send_request(OP_ALLOC, addr_t'($urandom_range(size_cap, 8 * size_cap)), ans);
      end
    end
  endtask

  task automatic test_reset_values();
    check_register(REG_HEAP_BASE, RESET_BASE);
    check_register(REG_HEAP_LIMIT, RESET_LIMIT);
  endtask

  // Walks through the corner cases on an empty table at the reset settings.
  task automatic test_directed();
    answer_t ans;
    addr_t   blk_a;
    addr_t   blk_b;
    addr_t   blk_c;
    send_request(OP_ALLOC, '0, ans);           // zero size
    send_request(OP_FREE, '0, ans);            // null free
    send_request(OP_FREE, ADDR_MAX, ans);      // unknown address, all ones
    send_request(OP_ALLOC, ADDR_MAX, ans);     // growth past the limit
    send_request(OP_ALLOC, 24'd100, ans);
    blk_a = ans.address;
    send_request(OP_ALLOC, 24'd40, ans);
    blk_b = ans.address;
    send_request(OP_ALLOC, 24'd1, ans);
    blk_c = ans.address;
    send_request(OP_FREE, blk_a, ans);         // first entry is only marked
    send_request(OP_FREE, blk_a, ans);         // freeing it again is accepted
    send_request(OP_ALLOC, 24'd200, ans);      // too big for the hole: append
    send_request(OP_ALLOC, 24'd100, ans);      // exact fit reuses the hole
    send_request(OP_FREE, blk_a, ans);
    send_request(OP_ALLOC, 24'd60, ans);       // smaller fit keeps the old size
    send_request(OP_ALLOC, 24'd100, ans);      // hole busy again: append
    send_request(OP_FREE, blk_b + 24'd1, ans); // one past a payload address
    send_request(OP_FREE, blk_b - addr_t'(HEADER_BYTES), ans); // header address
    send_request(OP_FREE, payload_of(blk_count - 1), ans);     // last entry goes
    send_request(OP_ALLOC, 24'd10, ans);       // lands where the last one was
    send_request(OP_FREE, blk_c, ans);
    drain_table();
    send_request(OP_ALLOC, 24'd1, ans);        // starts again at the heap base
  endtask

  // Fills the table, then asks for blocks that no hole can hold.
  task automatic test_table_full();
    answer_t     ans;
    int unsigned guard;
    guard = 0;
    while (blk_count < MAX_BLOCKS && guard < 4 * MAX_BLOCKS) begin
      send_request(OP_ALLOC, addr_t'($urandom_range(1, 64)), ans);
      guard++;
    end
    repeat (3) send_request(OP_ALLOC, addr_t'($urandom_range(4096, 65536)), ans);
    // The limit is checked first, even with the table full.
    send_request(OP_ALLOC, ADDR_MAX, ans);
    // A full table still hands out its holes.
    send_request(OP_FREE, payload_of(MAX_BLOCKS / 2), ans);
    send_request(OP_ALLOC, 24'd1, ans);
    send_request(OP_ALLOC, 24'd1, ans);
  endtask

  task automatic test_mixed_traffic(input int unsigned count, input int unsigned alloc_pct,
                                    input int unsigned size_cap);
    repeat (count) send_random_item(alloc_pct, size_cap);
  endtask

  // A long stretch in which neither side holds back.
  task automatic test_steady_stream();
    idle_pct = 0;
    test_mixed_traffic(200, 55, 256);
    idle_pct = 33;
  endtask

  // The base moves while entries still exist and only counts once the table
  // empties; the low limit makes growth fail often.
  task automatic test_tight_heap();
    write_register(REG_HEAP_BASE, 24'd1);
    write_register(REG_HEAP_LIMIT, 24'd3000);
    test_mixed_traffic(300, 60, 120);
  endtask

  task automatic test_heap_extremes();
    answer_t ans;
    drain_table();
    write_register(REG_HEAP_BASE, ADDR_MAX);
    write_register(REG_HEAP_LIMIT, ADDR_MAX);
    send_request(OP_ALLOC, 24'd1, ans);        // base at the limit cannot grow
    write_register(REG_HEAP_LIMIT, 24'd1);
    send_request(OP_ALLOC, 24'd1, ans);        // base above the limit
    write_register(REG_HEAP_BASE, 24'd1);
    send_request(OP_ALLOC, 24'd1, ans);
    write_register(REG_HEAP_LIMIT, ADDR_MAX);
    send_request(OP_ALLOC, ADDR_MAX, ans);     // overflows the address space
    // Exactly reaches the top of the address space.
    send_request(OP_ALLOC, ADDR_MAX - addr_t'(HEADER_BYTES) - 24'd1, ans);
    send_request(OP_ALLOC, 24'd1, ans);        // break is at the top now
    send_request(OP_FREE, ans.address, ans);   // null: the grant above failed
    drain_table();
  endtask

  // The receiver refuses answers for a long time while requests keep coming,
  // so the block must stall its input.
  task automatic test_backpressure();
    write_register(REG_HEAP_BASE, RESET_BASE);
    write_register(REG_HEAP_LIMIT, RESET_LIMIT);
    -> start_holdoff;
    test_mixed_traffic(40, 55, 256);
  endtask

  // A random heap window, each time from an empty table.
  task automatic test_random_heap();
    addr_t base;
    repeat (5) begin
      drain_table();
      base = addr_t'($urandom_range(1, 24'h7FFFFF));
      write_register(REG_HEAP_BASE, base);
      write_register(REG_HEAP_LIMIT, base + addr_t'($urandom_range(2000, 40000)));
      test_mixed_traffic(70, 55, 512);
    end
  endtask

  // Receiver side: random stalls, or a solid hold-off when one is running.
  always @(negedge clk_i) begin
    if (holding) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // The hold-off counts its own cycles on the rising edge, so the receiver
  // reads a settled flag at the falling edge.
  always begin
    @(start_holdoff);
    @(posedge clk_i);
    holding = 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    holding = 1'b0;
  end

  // Every answer taken from the block is matched against the oldest owed one.
  always @(posedge clk_i) begin : check_answers
    answer_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("answer with nothing owed", 32'(m_axis_tuser), 32'(0));
      end else begin
        want = expected_answers.pop_front();
        if (m_axis_tdata !== want.address) begin
          report_mismatch("result_address", 32'(m_axis_tdata), 32'(want.address));
        end
        if (m_axis_tuser[0] !== want.reused) begin
          report_mismatch("reused", 32'(m_axis_tuser[0]), 32'(want.reused));
        end
        if (m_axis_tuser[3:1] !== want.status) begin
          report_mismatch("status", 32'(m_axis_tuser[3:1]), 32'(want.status));
        end
      end
    end
  end

  // Ends the run if neither stream nor the register port moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready) ||
        (psel && penable && pready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_first_fit_block_allocator: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_directed();
    test_table_full();
    test_mixed_traffic(500, 55, 256);
    test_steady_stream();
    test_tight_heap();
    test_heap_extremes();
    test_backpressure();
    test_random_heap();
    wait_idle();
    if (error_count == 0) begin
      $display("tb_first_fit_block_allocator: clean");
    end else begin
      $display("tb_first_fit_block_allocator: errors");
    end
    $finish;
  end

endmodule

### files.f
src/ffba_pkg.sv
src/ffba_table.sv
src/first_fit_block_allocator.sv
verif/tb_first_fit_block_allocator.sv
